[src/fpa_pkg.sv]
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int DATA_W            = 32;
   localparam int WIDE_W            = 64;
   localparam int MID_DEPTH         = 4;
   localparam int OUT_DEPTH         = 2;

   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_MIN      = 4'd4,
      ACT_MAX      = 4'd5,
      ACT_INC      = 4'd6,
      ACT_DEC      = 4'd7,
      ACT_FROM_INT = 4'd8,
      ACT_TO_INT   = 4'd9
   } action_type;

   // How the back end carries an item out.
   typedef enum logic [2:0] {
      KIND_SUM,
      KIND_SHL,
      KIND_SHR,
      KIND_MUL,
      KIND_DIV,
      KIND_ZERO
   } kind_type;

   typedef struct packed {
      logic [3:0]               action;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic                     a_greater;
      logic                     a_less;
      logic                     equal;
      logic                     saturated;
      logic                     divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic a_greater;
      logic a_less;
      logic equal;
   } cmp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      kind_type                 kind;
      logic                     neg;
      cmp_type                  cmp;
      logic                     dbz;
      logic signed [DATA_W:0]   x;
      logic signed [DATA_W:0]   y;
      logic [DATA_W-1:0]        mag_a;
      logic [DATA_W-1:0]        mag_b;
   } work_type;

endpackage

[src/fpa_fifo.sv]
`timescale 1ns / 1ps
module fpa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/fpa_front.sv]
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   input  logic     work_pop,
   output logic     work_empty,
   output work_type work_data
);

   work_type               cls;
   logic signed [DATA_W:0] a_ext, b_ext;
   logic [$bits(work_type)-1:0] work_bits;

   always_comb begin
      a_ext = {req_data.operand_a[DATA_W-1], req_data.operand_a};
      b_ext = {req_data.operand_b[DATA_W-1], req_data.operand_b};
      cls   = '0;
      cls.cmp.a_greater = req_data.operand_a > req_data.operand_b;
      cls.cmp.a_less    = req_data.operand_a < req_data.operand_b;
      cls.cmp.equal     = req_data.operand_a == req_data.operand_b;
      cls.neg   = req_data.operand_a[DATA_W-1] ^ req_data.operand_b[DATA_W-1];
      // -(-2^31) wraps to the bit pattern of +2^31, which is the magnitude wanted
      cls.mag_a = req_data.operand_a[DATA_W-1] ? DATA_W'(-req_data.operand_a)
                                                : DATA_W'(req_data.operand_a);
      cls.mag_b = req_data.operand_b[DATA_W-1] ? DATA_W'(-req_data.operand_b)
                                                : DATA_W'(req_data.operand_b);
      cls.kind  = KIND_ZERO;
      case (req_data.action)
         ACT_ADD: begin
            cls.kind = KIND_SUM;
            cls.x    = a_ext;
            cls.y    = b_ext;
         end
         ACT_SUB: begin
            cls.kind = KIND_SUM;
            cls.x    = a_ext;
            cls.y    = -b_ext;
         end
         ACT_MUL: begin
            cls.kind = KIND_MUL;
         end
         ACT_DIV: begin
            if (req_data.operand_b == '0) begin
               cls.dbz = 1'b1;
            end else begin
               cls.kind = KIND_DIV;
            end
         end
         ACT_MIN: begin
            cls.kind = KIND_SUM;
            cls.x    = cls.cmp.a_less ? a_ext : b_ext;
         end
         ACT_MAX: begin
            cls.kind = KIND_SUM;
            cls.x    = cls.cmp.a_greater ? a_ext : b_ext;
         end
         ACT_INC: begin
            cls.kind = KIND_SUM;
            cls.x    = a_ext;
            cls.y    = (DATA_W + 1)'(1);
         end
         ACT_DEC: begin
            cls.kind = KIND_SUM;
            cls.x    = a_ext;
            cls.y    = '1;
         end
         ACT_FROM_INT: begin
            cls.kind = KIND_SHL;
            cls.x    = a_ext;
         end
         ACT_TO_INT: begin
            cls.kind = KIND_SHR;
            cls.x    = a_ext;
         end
         default: begin
            cls.kind = KIND_ZERO;
         end
      endcase
   end

   fpa_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .full      (full),
      .pop       (work_pop),
      .empty     (work_empty),
      .pop_data  (work_bits)
   );

   assign work_data = work_type'(work_bits);

endmodule

[src/fpa_back.sv]
`timescale 1ns / 1ps
module fpa_back import fpa_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     work_empty,
   output logic     work_pop,
   input  work_type work_data,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   localparam int RES_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
   localparam int NUM_W    = DATA_W + FRAC_BITS;   // dividend bits, one stage each
   localparam int LAST     = NUM_W + 2;
   localparam int STAGES   = LAST + 1;

   localparam logic [WIDE_W-1:0] NEG_LIM    = WIDE_W'(1) << (RES_BITS - 1);
   localparam logic [WIDE_W-1:0] POS_LIM    = NEG_LIM - WIDE_W'(1);
   localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] HI_RES     = POS_LIM[DATA_W-1:0];
   localparam logic [DATA_W-1:0] LO_RES     = DATA_W'(~POS_LIM);
   localparam logic signed [WIDE_W-1:0] HI_WIDE = signed'(POS_LIM);
   localparam logic signed [WIDE_W-1:0] LO_WIDE = signed'(~POS_LIM);

   typedef struct packed {
      kind_type                 kind;
      logic                     neg;
      cmp_type                  cmp;
      logic                     dbz;
      logic signed [DATA_W-1:0] res;
      logic                     sat;
      logic [WIDE_W-1:0]        acc;
      logic [DATA_W-1:0]        rem;
      logic [DATA_W-1:0]        dvs;
   } stage_type;

   stage_type                stage_ff [STAGES];
   stage_type                stage_in [STAGES];
   logic [STAGES-1:0]        valid_ff, valid_in;
   logic signed [WIDE_W-1:0] wide_v;
   logic                     advance;
   logic                     out_push, out_full;
   rsp_type                  out_data;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // Magnitude plus sign to a clamped result.
   function automatic stage_type finish_mag(input stage_type s);
      stage_type t;
      t = s;
      if (!s.neg) begin
         t.sat = s.acc > POS_LIM;
         t.res = t.sat ? HI_RES : s.acc[DATA_W-1:0];
      end else begin
         t.sat = s.acc > NEG_LIM;
         t.res = t.sat ? LO_RES : DATA_W'(-s.acc[DATA_W-1:0]);
      end
      return t;
   endfunction

   function automatic stage_type finish_direct(input stage_type s);
      stage_type                t;
      logic signed [WIDE_W-1:0] v;
      t = s;
      v = signed'(s.acc);
      t.sat = (v > HI_WIDE) || (v < LO_WIDE);
      if (v > HI_WIDE) begin
         t.res = HI_RES;
      end else if (v < LO_WIDE) begin
         t.res = LO_RES;
      end else begin
         t.res = v[DATA_W-1:0];
      end
      return t;
   endfunction

   function automatic stage_type mul_round(input stage_type s);
      stage_type t;
      t = s;
      t.acc = (s.acc + ROUND_HALF) >> FRAC_BITS;
      return t;
   endfunction

   // One restoring step: quotient bits shift in at the bottom of acc.
   function automatic stage_type div_step(input stage_type s);
      stage_type       t;
      logic [DATA_W:0] trial;
      logic            qbit;
      t     = s;
      trial = {s.rem, s.acc[NUM_W-1]};
      qbit  = trial >= {1'b0, s.dvs};
      t.rem = qbit ? DATA_W'(trial - {1'b0, s.dvs}) : trial[DATA_W-1:0];
      t.acc = WIDE_W'({s.acc[NUM_W-2:0], qbit});
      return t;
   endfunction

   // Half up on the magnitude: twice the remainder against the divisor.
   function automatic stage_type div_round(input stage_type s);
      stage_type t;
      t = s;
      t.acc = s.acc + WIDE_W'({s.rem, 1'b0} >= {1'b0, s.dvs});
      return t;
   endfunction

   assign advance  = !(valid_ff[LAST] && out_full);
   assign work_pop = advance && !work_empty;
   assign out_push = advance && valid_ff[LAST];
   assign valid_in = {valid_ff[STAGES-2:0], !work_empty};

   always_comb begin
      wide_v            = '0;
      stage_in[0]       = '0;
      stage_in[0].kind  = work_data.kind;
      stage_in[0].neg   = work_data.neg;
      stage_in[0].cmp   = work_data.cmp;
      stage_in[0].dbz   = work_data.dbz;
      stage_in[0].dvs   = work_data.mag_b;
      case (work_data.kind)
         KIND_SUM: wide_v = WIDE_W'(work_data.x) + WIDE_W'(work_data.y);
         KIND_SHL: wide_v = WIDE_W'(work_data.x) <<< FRAC_BITS;
         KIND_SHR: wide_v = WIDE_W'(work_data.x) >>> FRAC_BITS;
         default:  wide_v = '0;
      endcase
      if (work_data.kind inside {KIND_SUM, KIND_SHL, KIND_SHR}) begin
         stage_in[0].acc = wide_v;
      end else if (work_data.kind == KIND_MUL) begin
         stage_in[0].acc = WIDE_W'(work_data.mag_a) * WIDE_W'(work_data.mag_b);
      end else if (work_data.kind == KIND_DIV) begin
         stage_in[0].acc = WIDE_W'(work_data.mag_a) << FRAC_BITS;
      end

      for (int i = 1; i < STAGES; i++) begin
         stage_in[i] = stage_ff[i-1];
         case (stage_ff[i-1].kind)
            KIND_SUM, KIND_SHL, KIND_SHR: begin
               if (i == 1) stage_in[i] = finish_direct(stage_ff[i-1]);
            end
            KIND_MUL: begin
               if (i == 1) begin
                  stage_in[i] = mul_round(stage_ff[i-1]);
               end else if (i == 2) begin
                  stage_in[i] = finish_mag(stage_ff[i-1]);
               end
            end
            KIND_DIV: begin
               if (i <= NUM_W) begin
                  stage_in[i] = div_step(stage_ff[i-1]);
               end else if (i == NUM_W + 1) begin
                  stage_in[i] = div_round(stage_ff[i-1]);
               end else begin
                  stage_in[i] = finish_mag(stage_ff[i-1]);
               end
            end
            default: begin
               stage_in[i] = stage_ff[i-1];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      out_data.result         = stage_ff[LAST].res;
      out_data.a_greater      = stage_ff[LAST].cmp.a_greater;
      out_data.a_less         = stage_ff[LAST].cmp.a_less;
      out_data.equal          = stage_ff[LAST].cmp.equal;
      out_data.saturated      = stage_ff[LAST].sat;
      out_data.divide_by_zero = stage_ff[LAST].dbz;
   end

   fpa_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);

   a_dbz_gives_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && stage_ff[LAST].dbz |->
         stage_ff[LAST].res == '0 && !stage_ff[LAST].sat)
      else $error("divide by zero left with nonzero or clamped result");

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |-> $onehot(stage_ff[LAST].cmp))
      else $error("compare flags not exactly one of greater, less, equal");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && stage_ff[LAST].sat |->
         stage_ff[LAST].res == HI_RES || stage_ff[LAST].res == LO_RES)
      else $error("clamped result is not a range bound");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while output queue was full");

endmodule

[src/fixed_point_alu.sv]
`timescale 1ns / 1ps
// Channel   Ports                          Transfer when
// request   push, full, req_data           push && !full
// response  empty, pop, rsp_data           pop && !empty
//
// One item is taken per cycle while full is low, every action on the same path.
// Every item passes through the whole back pipeline, whose length is set by the
// divide path that resolves one quotient bit per stage.
// Reset clears queue pointers and pipeline valid bits; data registers are not reset.
// A full response queue holds the whole back pipeline; the 4-entry middle queue
// then fills and raises full.
module fixed_point_alu import fpa_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   work_type work_data;
   logic     work_empty;
   logic     work_pop;

   fpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .work_pop   (work_pop),
      .work_empty (work_empty),
      .work_data  (work_data)
   );

   fpa_back #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .work_data  (work_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

[sim/fixed_point_alu_tb.sv]
`timescale 1ns / 1ps
module fixed_point_alu_tb;
   import fpa_pkg::*;

   localparam int          FRAC          = FRAC_BITS_DEFAULT;
   localparam longint      RES_HI        = 64'sd2147483647;
   localparam longint      RES_LO        = -RES_HI - 1;
   localparam logic [31:0] RAW_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] RAW_MIN       = 32'h8000_0000;
   localparam logic [3:0]  ACT_SPARE_LO  = 4'd10;
   localparam logic [3:0]  ACT_SPARE_HI  = 4'd15;
   localparam int          RANDOM_ITEMS  = 825;
   localparam int          QUIET_TAIL    = 150;
   localparam int          LONG_HOLD     = 250;
   localparam int          DRAIN_CYCLES  = 80;
   localparam int          CYCLE_LIMIT   = 400000;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type want;
   } drill_row_type;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   rsp_type       expected_rsps[$];
   drill_row_type drill_rows[$];
   int            errors        = 0;
   int            n_sent        = 0;
   int            n_results     = 0;
   int            n_sat         = 0;
   int            n_dbz         = 0;
   int            n_full_cycles = 0;
   int            cycle_count   = 0;
   bit            gaps_on       = 1'b1;
   bit            long_hold_due = 1'b0;

   fixed_point_alu u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Exact arithmetic in 64 bits, halves rounded away from zero, clamp to 32 bits.
   function automatic rsp_type predict_alu(req_type rq);
      longint          a, b, r;
      longint unsigned ma, mb, q;
      bit              neg;
      rsp_type         p;
      a   = longint'($signed(rq.operand_a));
      b   = longint'($signed(rq.operand_b));
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      p   = '0;
      r   = 0;
      case (rq.action)
         ACT_ADD:      r = a + b;
         ACT_SUB:      r = a - b;
         ACT_MUL: begin
            q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
            r = neg ? -longint'(q) : longint'(q);
         end
         ACT_DIV: begin
            if (b == 0) begin
               p.divide_by_zero = 1'b1;
            end else begin
               q = (2 * (ma << FRAC) + mb) / (2 * mb);
               r = neg ? -longint'(q) : longint'(q);
            end
         end
         ACT_MIN:      r = (a < b) ? a : b;
         ACT_MAX:      r = (a > b) ? a : b;
         ACT_INC:      r = a + 1;
         ACT_DEC:      r = a - 1;
         ACT_FROM_INT: r = a * (longint'(1) << FRAC);
         ACT_TO_INT:   r = a >>> FRAC;
         default:      r = 0;
      endcase
      if (r > RES_HI) begin
         r = RES_HI;
         p.saturated = 1'b1;
      end else if (r < RES_LO) begin
         r = RES_LO;
         p.saturated = 1'b1;
      end
      p.result    = r[31:0];
      p.a_greater = a > b;
      p.a_less    = a < b;
      p.equal     = a == b;
      return p;
   endfunction

   // flags: a_greater a_less equal saturated divide_by_zero
   task automatic add_row(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b,
                          input bit known, input logic [31:0] res, input logic [4:0] flags);
      drill_row_type row;
      row.req.action    = act;
      row.req.operand_a = a;
      row.req.operand_b = b;
      row.known         = known;
      row.want          = {res, flags};
      drill_rows.push_back(row);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return 32'($urandom_range(0, 1023)) - 32'd512;
         2: begin
            case ($urandom_range(0, 4))
               0:       return RAW_MAX;
               1:       return RAW_MIN;
               2:       return 32'd0;
               3:       return 32'hFFFF_FFFF;
               default: return 32'd1;
            endcase
         end
         3:       return (32'($urandom_range(0, 255)) - 32'd128) << FRAC;
         4:       return 32'($urandom_range(0, 131071)) - 32'd65536;
         default: return $urandom();
      endcase
   endfunction

   // Optional idle burst, then offer the item until the transfer happens.
   task automatic send_item(input req_type rq, input rsp_type want);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (full);
      expected_rsps.push_back(want);
      n_sent++;
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && pop && !empty) begin
         n_results++;
         if (rsp_data.saturated === 1'b1) n_sat++;
         if (rsp_data.divide_by_zero === 1'b1) n_dbz++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            check_field("result",         want.result,         rsp_data.result);
            check_field("a_greater",      want.a_greater,      rsp_data.a_greater);
            check_field("a_less",         want.a_less,         rsp_data.a_less);
            check_field("equal",          want.equal,          rsp_data.equal);
            check_field("saturated",      want.saturated,      rsp_data.saturated);
            check_field("divide_by_zero", want.divide_by_zero, rsp_data.divide_by_zero);
         end
      end
      if (!reset && push && full) n_full_cycles++;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_rsps.size());
         $display("fixed_point_alu test failed");
         $finish;
      end
   end

   // Receiver: random pop stalls, plus one long hold so the pipeline backs up.
   initial begin
      pop = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 14)) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_type rq;
      rsp_type want;
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;

      add_row(ACT_ADD,      RAW_MAX,      32'd1,        1, RAW_MAX,      5'b10010);
      add_row(ACT_ADD,      RAW_MIN,      RAW_MIN,      1, RAW_MIN,      5'b00110);
      add_row(ACT_SUB,      RAW_MIN,      32'd1,        1, RAW_MIN,      5'b01010);
      add_row(ACT_SUB,      32'd0,        RAW_MIN,      1, RAW_MAX,      5'b10010);
      add_row(ACT_MUL,      32'h100,      32'h100,      1, 32'h100,      5'b00100);
      add_row(ACT_MUL,      RAW_MAX,      RAW_MAX,      1, RAW_MAX,      5'b00110);
      add_row(ACT_MUL,      RAW_MIN,      RAW_MAX,      1, RAW_MIN,      5'b01010);
      // half a raw step rounds away from zero, both signs
      add_row(ACT_MUL,      32'h80,       32'd1,        0, '0,           '0);
      add_row(ACT_MUL,      32'hFFFF_FF80, 32'd1,       0, '0,           '0);
      add_row(ACT_DIV,      32'h1234,     32'd0,        1, 32'd0,        5'b10001);
      add_row(ACT_DIV,      RAW_MIN,      32'd0,        1, 32'd0,        5'b01001);
      add_row(ACT_DIV,      RAW_MIN,      32'hFFFF_FFFF, 1, RAW_MAX,     5'b01010);
      add_row(ACT_DIV,      32'h100,      32'h300,      0, '0,           '0);
      add_row(ACT_MIN,      RAW_MIN,      RAW_MAX,      1, RAW_MIN,      5'b01000);
      add_row(ACT_MAX,      RAW_MIN,      RAW_MAX,      1, RAW_MAX,      5'b01000);
      add_row(ACT_INC,      RAW_MAX,      32'd0,        1, RAW_MAX,      5'b10010);
      add_row(ACT_DEC,      RAW_MIN,      32'd0,        1, RAW_MIN,      5'b01010);
      add_row(ACT_FROM_INT, 32'h0080_0000, 32'd0,       1, RAW_MAX,      5'b10010);
      add_row(ACT_FROM_INT, 32'hFF80_0000, 32'd0,       1, RAW_MIN,      5'b01000);
      add_row(ACT_FROM_INT, 32'hFF7F_FFFF, 32'd0,       1, RAW_MIN,      5'b01010);
      add_row(ACT_TO_INT,   32'hFFFF_FFFF, 32'd0,       1, 32'hFFFF_FFFF, 5'b01000);
      add_row(ACT_TO_INT,   RAW_MAX,      RAW_MAX,      1, 32'h007F_FFFF, 5'b00100);
      add_row(ACT_TO_INT,   RAW_MIN,      RAW_MIN,      1, 32'hFF80_0000, 5'b00100);
      add_row(ACT_SPARE_LO, 32'd5,        32'd5,        1, 32'd0,        5'b00100);
      add_row(ACT_SPARE_HI, 32'hDEAD_BEEF, 32'h1234_5678, 0, '0,         '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_rows[i]) begin
         want = drill_rows[i].known ? drill_rows[i].want : predict_alu(drill_rows[i].req);
         send_item(drill_rows[i].req, want);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         if (i >= RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
         if (i == 100) long_hold_due = 1'b1;
         if ($urandom_range(0, 15) == 0)
            rq.action = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         else
            rq.action = 4'($urandom_range(ACT_ADD, ACT_TO_INT));
         rq.operand_a = random_operand();
         rq.operand_b = random_operand();
         // push divides toward the zero-divisor case now and then
         if (rq.action == ACT_DIV && $urandom_range(0, 7) == 0) rq.operand_b = '0;
         send_item(rq, predict_alu(rq));
      end
      push <= 1'b0;

      wait (expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d directed, %0d random), checked %0d results.",
               n_sent, drill_rows.size(), RANDOM_ITEMS, n_results);
      $display("Saw %0d saturated, %0d divide-by-zero results; input stalled %0d cycles.",
               n_sat, n_dbz, n_full_cycles);
      if (errors == 0) begin
         $display("fixed_point_alu test passed");
      end else begin
         $display("fixed_point_alu test failed");
      end
      $finish;
   end

endmodule
